>>> rtl/core/min_heap_timer_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer queue.
// Both macros sample on the rising clock edge and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_TIMER_QUEUE_TOP_DEFINES_SVH
`define MIN_HEAP_TIMER_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MHTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mhtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_pkg
// Sizes, codes and types shared by the timer queue modules.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int CAPACITY  = 32;
  localparam int ID_COUNT  = 256;
  localparam int TIME_BITS = 48;

  localparam int ID_W      = 8;
  localparam int AMOUNT_W  = 31;
  localparam int TICK_W    = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CHILD_W   = SLOT_W + 2;

  localparam logic [TICK_W-1:0] INT_MAX = {1'b0, {(TICK_W - 1){1'b1}}};
  localparam logic [TICK_W-1:0] TICK_NONE = {TICK_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_ADJUST  = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_ADVANCE = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] dl;
  } heap_entry_t;

endpackage

>>> rtl/core/min_heap_timer_queue_top.sv
`timescale 1ns / 1ps
`include "min_heap_timer_queue_top_defines.svh"
// ----------------------------------------------------------------------------
// min_heap_timer_queue_top
// Timer queue on a binary min-heap of deadlines, one request at a time.
//
// Timers live in a heap memory of CAPACITY slots. A second memory maps each
// timer id to its slot, and a valid flag per id is kept in flops. Add, adjust
// and delete move a timer up or down the heap one level at a time. Every
// level costs one memory read and one compare-and-write through the single
// heap write port. An advance sets the clock, then pops each expired timer;
// its replacement sinks level by level, and every expired timer gives one
// result. The input is taken only in the idle state, which is entered once
// the last result of a request is loaded into the output register. A
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_top import mhtq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            action_i,
  input  logic [ID_W-1:0]       timer_id_i,
  input  logic [AMOUNT_W-1:0]   amount_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  expired_valid_o,
  output logic [ID_W-1:0]       expired_id_o,
  output logic signed [TICK_W-1:0] next_tick_ms_o,
  output logic [CNT_W-1:0]      timer_count_o,
  output logic                  last_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LOADMOV, S_DOWN_RD, S_DOWN_CMP,
    S_UP_RD, S_UP_CMP, S_POP, S_FIN_RD, S_EMIT
  } state_e;

  state_e               state_q;
  logic [2:0]           act_q;
  logic [ID_W-1:0]      id_q;
  logic [TIME_BITS-1:0] dl_q;
  logic [TIME_BITS-1:0] clock_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SLOT_W-1:0]    hole_q;
  logic [ID_W-1:0]      mov_id_q;
  logic [TIME_BITS-1:0] mov_dl_q;
  logic                 moved_q;
  logic                 fire_q;
  logic [ID_W-1:0]      fired_id_q;
  status_e              status_q;
  logic [ID_COUNT-1:0]  pos_valid_q;

  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic                 out_exp_valid_q;
  logic [ID_W-1:0]      out_exp_id_q;
  logic [TICK_W-1:0]    out_tick_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_last_q;

  // Heap memory: two read ports, one write port, registered reads.
  heap_entry_t          heap_mem [CAPACITY];
  heap_entry_t          rd_a_q, rd_b_q;
  logic [SLOT_W-1:0]    addr_a, addr_b;
  logic                 heap_we;
  logic [SLOT_W-1:0]    heap_wa;
  heap_entry_t          heap_wd;

  // Position memory: id to slot.
  logic [SLOT_W-1:0]    pos_mem [ID_COUNT];
  logic [SLOT_W-1:0]    pos_rd_q;
  logic                 pos_we;
  logic [ID_W-1:0]      pos_wa;
  logic [SLOT_W-1:0]    pos_wd;

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    rd_a_q <= heap_mem[addr_a];
    rd_b_q <= heap_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_q <= pos_mem[timer_id_i];
  end

  // Saturating clock plus amount.
  logic [TIME_BITS:0]   sum_full;
  logic [TIME_BITS-1:0] sum_sat;
  assign sum_full = {1'b0, clock_q} + (TIME_BITS + 1)'(amount_ms_i);
  assign sum_sat  = sum_full[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

  // Heap index arithmetic around the hole.
  logic [CHILD_W-1:0]   left_idx, right_idx;
  logic [SLOT_W-1:0]    parent_idx;
  logic                 l_ok, r_ok, take_l, take_r, stop;
  logic [TIME_BITS-1:0] best_dl;
  heap_entry_t          child;
  logic [CHILD_W-1:0]   child_idx;
  logic [CNT_W-1:0]     last_slot;

  assign left_idx   = {1'b0, hole_q, 1'b1};
  assign right_idx  = left_idx + CHILD_W'(1);
  assign parent_idx = (hole_q - SLOT_W'(1)) >> 1;
  assign l_ok       = left_idx < CHILD_W'(cnt_q);
  assign r_ok       = right_idx < CHILD_W'(cnt_q);
  assign take_l     = l_ok && (rd_a_q.dl < mov_dl_q);
  assign best_dl    = take_l ? rd_a_q.dl : mov_dl_q;
  assign take_r     = r_ok && (rd_b_q.dl < best_dl);
  assign stop       = !take_l && !take_r;
  assign child      = take_r ? rd_b_q : rd_a_q;
  assign child_idx  = take_r ? right_idx : left_idx;
  assign last_slot  = cnt_q - CNT_W'(1);

  always_comb begin
    addr_a  = '0;
    addr_b  = '0;
    heap_we = 1'b0;
    heap_wa = hole_q;
    heap_wd = '{id: mov_id_q, dl: mov_dl_q};
    pos_we  = 1'b0;
    pos_wa  = mov_id_q;
    pos_wd  = hole_q;
    unique case (state_q)
      S_DISPATCH: begin
        addr_b = last_slot[SLOT_W-1:0];
      end
      S_POP: begin
        addr_b = last_slot[SLOT_W-1:0];
      end
      S_DOWN_RD: begin
        addr_a = left_idx[SLOT_W-1:0];
        addr_b = right_idx[SLOT_W-1:0];
      end
      S_DOWN_CMP: begin
        if (!stop) begin
          heap_we = 1'b1;
          heap_wd = child;
          pos_we  = 1'b1;
          pos_wa  = child.id;
        end else if (moved_q) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      S_UP_RD: begin
        addr_a = parent_idx;
        if (hole_q == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (mov_dl_q < rd_a_q.dl) begin
          heap_wd = rd_a_q;
          pos_wa  = rd_a_q.id;
        end
      end
      default: begin
      end
    endcase
  end

  logic [TICK_W-1:0] next_tick;
  logic              root_due;

  mhtq_tick u_tick (
    .count_i     (cnt_q),
    .root_dl_i   (rd_a_q.dl),
    .clock_i     (clock_q),
    .next_tick_o (next_tick)
  );

  assign root_due = (cnt_q != '0) && (rd_a_q.dl <= clock_q);

  logic pos_hit;
  assign pos_hit = pos_valid_q[id_q];

  // A result is loaded into the output register in this cycle.
  logic emit_go;
  assign emit_go = (state_q == S_EMIT) && !((act_q == ACT_ADVANCE) && root_due && !fire_q)
                   && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      clock_q     <= '0;
      pos_valid_q <= '0;
      out_valid_q <= 1'b0;
      fire_q      <= 1'b0;
      moved_q     <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q    <= action_i;
            id_q     <= timer_id_i;
            dl_q     <= sum_sat;
            fire_q   <= 1'b0;
            status_q <= ST_OK;
            if (action_i == ACT_ADVANCE) begin
              clock_q <= sum_sat;
            end
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          mov_id_q <= id_q;
          mov_dl_q <= dl_q;
          moved_q  <= 1'b0;
          state_q  <= S_FIN_RD;
          unique case (act_q)
            ACT_ADD, ACT_ADJUST: begin
              if (pos_hit) begin
                hole_q  <= pos_rd_q;
                state_q <= S_DOWN_RD;
              end else if (act_q == ACT_ADJUST) begin
                status_q <= ST_NOT_FOUND;
              end else if (cnt_q == CNT_W'(CAPACITY)) begin
                status_q <= ST_FULL;
              end else begin
                hole_q            <= cnt_q[SLOT_W-1:0];
                pos_valid_q[id_q] <= 1'b1;
                cnt_q             <= cnt_q + CNT_W'(1);
                state_q           <= S_UP_RD;
              end
            end
            ACT_DELETE: begin
              if (!pos_hit) begin
                status_q <= ST_NOT_FOUND;
              end else begin
                pos_valid_q[id_q] <= 1'b0;
                cnt_q             <= last_slot;
                hole_q            <= pos_rd_q;
                // The last timer fills the hole unless the hole is the last slot.
                if (CNT_W'(pos_rd_q) < last_slot) begin
                  state_q <= S_LOADMOV;
                end
              end
            end
            ACT_CLEAR: begin
              pos_valid_q <= '0;
              cnt_q       <= '0;
            end
            default: begin
            end
          endcase
        end
        S_LOADMOV: begin
          mov_id_q <= rd_b_q.id;
          mov_dl_q <= rd_b_q.dl;
          moved_q  <= 1'b0;
          state_q  <= S_DOWN_RD;
        end
        S_DOWN_RD: begin
          state_q <= S_DOWN_CMP;
        end
        S_DOWN_CMP: begin
          if (!stop) begin
            hole_q  <= child_idx[SLOT_W-1:0];
            moved_q <= 1'b1;
            state_q <= S_DOWN_RD;
          end else if (moved_q) begin
            state_q <= S_FIN_RD;
          end else begin
            state_q <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          state_q <= (hole_q == '0) ? S_FIN_RD : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (mov_dl_q < rd_a_q.dl) begin
            hole_q  <= parent_idx;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_FIN_RD;
          end
        end
        S_POP: begin
          fired_id_q              <= rd_a_q.id;
          pos_valid_q[rd_a_q.id]  <= 1'b0;
          cnt_q                   <= last_slot;
          fire_q                  <= 1'b1;
          hole_q                  <= '0;
          state_q                 <= (cnt_q > CNT_W'(1)) ? S_LOADMOV : S_FIN_RD;
        end
        S_FIN_RD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if ((act_q == ACT_ADVANCE) && root_due && !fire_q) begin
            state_q <= S_POP;
          end else if (!out_valid_q || out_ready_i) begin
            out_status_q    <= status_q;
            out_exp_valid_q <= fire_q;
            out_exp_id_q    <= fire_q ? fired_id_q : '0;
            out_tick_q      <= next_tick;
            out_cnt_q       <= cnt_q;
            out_last_q      <= !(fire_q && root_due);
            state_q         <= (fire_q && root_due) ? S_POP : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign expired_valid_o = out_exp_valid_q;
  assign expired_id_o    = out_exp_id_q;
  assign next_tick_ms_o  = out_tick_q;
  assign timer_count_o   = out_cnt_q;
  assign last_o          = out_last_q;

  `MHTQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "timer count above capacity")
  `MHTQ_ASSERT_IMPL(a_valid_count, state_q == S_IDLE, $countones(pos_valid_q) == int'(cnt_q), "valid ids disagree with count")
  `MHTQ_ASSERT_IMPL(a_fire_ok, out_valid_q && out_exp_valid_q, out_status_q == ST_OK, "expired result without ok status")
  `MHTQ_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, state_q == S_DISPATCH, "accepted request not dispatched")

endmodule

>>> rtl/core/mhtq_tick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhtq_tick
// Time until the earliest deadline; no tick if past the signed 32-bit range.
// ----------------------------------------------------------------------------
module mhtq_tick import mhtq_pkg::*; (
  input  logic [CNT_W-1:0]     count_i,
  input  logic [TIME_BITS-1:0] root_dl_i,
  input  logic [TIME_BITS-1:0] clock_i,
  output logic [TICK_W-1:0]    next_tick_o
);

  logic [TIME_BITS-1:0] diff;
  logic                 far;

  assign diff = root_dl_i - clock_i;
  // Anything above the largest positive 32-bit value reads as "no tick".
  assign far  = |diff[TIME_BITS-1:TICK_W-1];

  always_comb begin
    if (count_i == '0) begin
      next_tick_o = TICK_NONE;
    end else if (root_dl_i <= clock_i) begin
      next_tick_o = '0;
    end else if (far) begin
      next_tick_o = TICK_NONE;
    end else begin
      next_tick_o = diff[TICK_W-1:0];
    end
  end

endmodule
